FILE: rtl/pid_pkg.sv
// Shared widths, register indexes and control types for the PID step block.
// Used by the channel interfaces, the divider, the multiply-accumulate unit and the top level.
// Depends on nothing.
`default_nettype none

package pid_pkg;

  // Field and datapath widths.
  localparam int DATA_W     = 16;  // target, measured, elapsed, gains, period
  localparam int ERR_W      = 17;  // target - measured
  localparam int DIFF_W     = 18;  // error - last error
  localparam int INT_W      = 48;  // integral accumulator
  localparam int DRIVE_W    = 32;  // saturated output and derivative
  localparam int OPA_W      = 17;  // multiplier operand a, signed
  localparam int OPB_W      = 33;  // multiplier operand b, signed
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int ACC_W      = 66;  // output sum held with 24 fraction bits
  localparam int ACC_FRAC   = 24;
  localparam int INT_SPLIT  = 24;  // integral is multiplied in two halves
  localparam int DIV_N_W    = DIFF_W + DATA_W;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_PERIOD = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_M_INT,
    S_M_P,
    S_M_ILO,
    S_M_IHI,
    S_A_IHI,
    S_WAIT_DIV,
    S_M_D,
    S_A_D,
    S_DONE
  } state_t;

  // Accumulator operations; the number gives the left shift of the product.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD16,
    ACC_ADD0,
    ACC_ADD16,
    ACC_ADD24
  } acc_op_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  // Status from the serial divider.
  typedef struct packed {
    logic busy;
    logic sat;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pid_if.sv
// Valid/ready channel interfaces for PID requests and results.
// Depends on pid_pkg for the field widths.
`default_nettype none

interface pid_in_if;
  import pid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] measured;
  logic        [DATA_W-1:0] elapsed;

  modport source (output valid, target, measured, elapsed, input ready);
  modport sink   (input valid, target, measured, elapsed, output ready);
endinterface

interface pid_out_if;
  import pid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [ERR_W-1:0]   error_now;
  logic                      clipped;

  modport source (output valid, drive, error_now, clipped, input ready);
  modport sink   (input valid, drive, error_now, clipped, output ready);
endinterface

`default_nettype wire

FILE: rtl/pid_div.sv
// Restoring serial divider for the derivative: (diff * 65536) / dt, truncated toward zero.
// One quotient bit per cycle, then saturation to 32 bits signed. Depends on pid_pkg.
`default_nettype none

module pid_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [pid_pkg::DIFF_W-1:0] diff,
  input  wire logic        [pid_pkg::DATA_W-1:0] divisor,
  output pid_pkg::div_stat_t                     stat,
  output logic signed [pid_pkg::DRIVE_W-1:0]     quotient
);
  import pid_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_N_W-1:0]   quo;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dsr;
  logic                 neg;

  logic [DIFF_W-1:0]    mag;
  logic [DATA_W:0]      rem_sh;
  logic                 take;
  logic                 big;
  logic                 is_min;
  logic                 sat;

  // Magnitude of the signed difference.
  assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem, quo[DIV_N_W-1]};
  assign take   = (rem_sh >= {1'b0, dsr});

  // Control: busy for one cycle per quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // Datapath: the quotient shifts into the dividend register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= {mag, {DATA_W{1'b0}}};
      rem <= '0;
      dsr <= divisor;
      neg <= diff[DIFF_W-1];
      cnt <= DIV_CNT_W'(DIV_N_W - 1);
    end else if (busy) begin
      rem <= take ? DATA_W'(rem_sh - {1'b0, dsr}) : rem_sh[DATA_W-1:0];
      quo <= {quo[DIV_N_W-2:0], take};
      cnt <= cnt - 1'b1;
    end
  end

  // Saturate the signed result to 32 bits.
  assign big    = |quo[DIV_N_W-1:DRIVE_W-1];
  assign is_min = (quo[DIV_N_W-1:DRIVE_W] == '0) && quo[DRIVE_W-1] &&
                  (quo[DRIVE_W-2:0] == '0);
  assign sat    = big && !(neg && is_min);

  always_comb begin
    if (sat) begin
      quotient = neg ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (neg) begin
      quotient = DRIVE_W'(-quo[DRIVE_W-1:0]);
    end else begin
      quotient = quo[DRIVE_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.sat  = sat;

endmodule

`default_nettype wire

FILE: rtl/pid_mac.sv
// Shared multiplier with a registered product and a shifting accumulator.
// Every product of the PID step passes through this one unit. Depends on pid_pkg.
`default_nettype none

module pid_mac (
  input  wire logic                              clk,
  input  wire pid_pkg::mac_ctrl_t                ctrl,
  input  wire logic signed [pid_pkg::OPA_W-1:0]  op_a,
  input  wire logic signed [pid_pkg::OPB_W-1:0]  op_b,
  output logic signed [pid_pkg::PROD_W-1:0]      prod,
  output logic signed [pid_pkg::ACC_W-1:0]       acc
);
  import pid_pkg::*;

  logic signed [ACC_W-1:0] prod_x;

  // Registered multiply.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  assign prod_x = ACC_W'(prod);

  // Accumulate the previous product at the scale the sequencer asks for.
  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD16: acc <= prod_x <<< 16;
      ACC_ADD0:   acc <= acc + prod_x;
      ACC_ADD16:  acc <= acc + (prod_x <<< 16);
      ACC_ADD24:  acc <= acc + (prod_x <<< 24);
      default:    acc <= acc;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/pid_step.sv
// PID controller step: sequencer, configuration registers, integral state and result register.
// Depends on pid_pkg, pid_if, pid_div and pid_mac.
//
// Usage:
//   Each request on the sample channel carries target, measured and elapsed. The block
//   answers with one result on the result channel: drive, error_now and clipped.
//   Gains and the fixed period are written through cfg_we / cfg_index / cfg_data while
//   no request is in flight; a fixed period of zero makes each request use its elapsed.
// Timing:
//   A request is accepted only when the sequencer is idle. The result waits on the serial
//   divider for the derivative, which produces one of 34 quotient bits per cycle; the shared
//   multiplier works through the proportional and integral products while the divider runs.
//   The sequencer is ready again in the cycle after it loads the result, so it takes a
//   new request only once the previous result has been loaded.
// Stalls:
//   The result sits in an output register. The next request is accepted while that
//   result waits; its own result is held back until the receiver has taken the previous.
// Reset:
//   rst is synchronous and active high. It clears the gains, the fixed period, the
//   integral, the last error and the result valid flag, and returns the sequencer to idle.
`default_nettype none

module pid_step (
  input  wire logic                             clk,
  input  wire logic                             rst,
  pid_in_if.sink                                sample,
  pid_out_if.source                             result,
  input  wire logic                             cfg_we,
  input  wire logic [pid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pid_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pid_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] gain_p;
  logic [DATA_W-1:0] gain_i;
  logic [DATA_W-1:0] gain_d;
  logic [DATA_W-1:0] fixed_period;

  // Controller state and per-request values.
  logic signed [ERR_W-1:0]  last_error;
  logic signed [INT_W-1:0]  integral_sum;
  logic signed [ERR_W-1:0]  err_r;
  logic        [DATA_W-1:0] dt_r;

  state_t state;
  state_t state_next;

  logic                      accept;
  logic                      out_free;
  logic                      int_upd;
  logic                      out_load;
  logic                      ready_c;
  mac_ctrl_t                 mac_ctrl;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  div_stat_t                 div_stat;
  logic signed [DRIVE_W-1:0] deriv;

  logic        [DATA_W-1:0]  dt_raw;
  logic        [DATA_W-1:0]  dt_sel;
  logic signed [ERR_W-1:0]   err_in;
  logic signed [DIFF_W-1:0]  diff_in;
  logic signed [INT_W:0]     int_sum;
  logic signed [INT_W-1:0]   int_sat;
  logic [ACC_W-1:DRIVE_W+ACC_FRAC-1] acc_top;
  logic                      drive_fits;
  logic signed [DRIVE_W-1:0] drive_sat;

  assign accept   = sample.valid && sample.ready;
  assign out_free = !result.valid || result.ready;
  assign sample.ready = ready_c;

  // Request decode: error, period selection and derivative difference.
  assign err_in  = ERR_W'(sample.target) - ERR_W'(sample.measured);
  assign dt_raw  = (fixed_period != '0) ? fixed_period : sample.elapsed;
  assign dt_sel  = (dt_raw == '0) ? DATA_W'(1) : dt_raw;
  assign diff_in = DIFF_W'(err_in) - DIFF_W'(last_error);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      fixed_period <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:       gain_p       <= cfg_data;
        REG_GAIN_I:       gain_i       <= cfg_data;
        REG_GAIN_D:       gain_d       <= cfg_data;
        REG_FIXED_PERIOD: fixed_period <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (sample.valid) state_next = S_M_INT;
      S_M_INT:    state_next = S_M_P;
      S_M_P:      state_next = S_M_ILO;
      S_M_ILO:    state_next = S_M_IHI;
      S_M_IHI:    state_next = S_A_IHI;
      S_A_IHI:    state_next = S_WAIT_DIV;
      S_WAIT_DIV: if (!div_stat.busy) state_next = S_M_D;
      S_M_D:      state_next = S_A_D;
      S_A_D:      state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, accumulator op and register strobes.
  always_comb begin
    ready_c         = 1'b0;
    int_upd         = 1'b0;
    out_load        = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = ACC_HOLD;
    op_a            = OPA_W'(err_r);
    op_b            = OPB_W'(signed'({1'b0, dt_r}));
    case (state)
      S_IDLE: begin
        ready_c = 1'b1;
      end
      S_M_INT: begin
        mac_ctrl.mul_en = 1'b1;
      end
      S_M_P: begin
        mac_ctrl.mul_en = 1'b1;
        int_upd         = 1'b1;
        op_a            = signed'({1'b0, gain_p});
        op_b            = OPB_W'(err_r);
      end
      S_M_ILO: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_LOAD16;
        op_a            = signed'({1'b0, gain_i});
        op_b            = OPB_W'(signed'({1'b0, integral_sum[INT_SPLIT-1:0]}));
      end
      S_M_IHI: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_ADD0;
        op_a            = signed'({1'b0, gain_i});
        op_b            = OPB_W'(signed'(integral_sum[INT_W-1:INT_SPLIT]));
      end
      S_A_IHI: begin
        mac_ctrl.acc_op = ACC_ADD24;
      end
      S_M_D: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = signed'({1'b0, gain_d});
        op_b            = OPB_W'(deriv);
      end
      S_A_D: begin
        mac_ctrl.acc_op = ACC_ADD16;
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Saturating integral update with the error * dt product.
  assign int_sum = (INT_W+1)'(integral_sum) + (INT_W+1)'(prod);
  assign int_sat = (int_sum[INT_W] != int_sum[INT_W-1]) ?
                   {int_sum[INT_W], {(INT_W-1){!int_sum[INT_W]}}} : int_sum[INT_W-1:0];

  // Request capture and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error   <= '0;
      integral_sum <= '0;
    end else begin
      if (accept) begin
        last_error <= err_in;
      end
      if (int_upd) begin
        integral_sum <= int_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r <= err_in;
      dt_r  <= dt_sel;
    end
  end

  // Drive: floor of the accumulated sum to whole units, saturated to 32 bits.
  assign acc_top    = acc[ACC_W-1:DRIVE_W+ACC_FRAC-1];
  assign drive_fits = (&acc_top) || !(|acc_top);
  assign drive_sat  = drive_fits ? acc[DRIVE_W+ACC_FRAC-1:ACC_FRAC] :
                      {acc[ACC_W-1], {(DRIVE_W-1){!acc[ACC_W-1]}}};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.drive     <= drive_sat;
      result.error_now <= err_r;
      result.clipped   <= div_stat.sat || !drive_fits;
    end
  end

  // Serial divider for the derivative.
  pid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .diff     (diff_in),
    .divisor  (dt_sel),
    .stat     (div_stat),
    .quotient (deriv)
  );

  // Shared multiplier and accumulator.
  pid_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

`ifndef NO_ASSERTIONS
  // The divider only runs while a request is being worked on.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while the sequencer is idle");

  // An accepted request starts the divider and the multiply sequence together.
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (div_stat.busy && state == S_M_INT))
    else $error("request accepted without starting divider and sequencer");

  // The derivative product is only formed from a finished quotient.
  a_deriv_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_M_D) |-> !div_stat.busy)
    else $error("derivative multiplied before the divider finished");

  // A new result only comes from the final sequencer step.
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the final step");
`endif

endmodule

`default_nettype wire
